// ----- design/cmpg_pkg.sv -----
// Shared types, constants and polynomial tables for the multi-polynomial CRC block.
`default_nettype none

package cmpg_pkg;

    localparam int unsigned MAX_DEGREE = 32;
    localparam int unsigned REM_W      = MAX_DEGREE;
    localparam int unsigned DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int unsigned BIT_IDX_W  = $clog2(MAX_DEGREE);
    localparam int unsigned NUM_POLY   = 4;
    localparam int unsigned SEL_W      = 2;

    // Generator polynomials without the leading x^degree term
    localparam logic [31:0] GEN_POLY [NUM_POLY] = '{
        32'h0000_00D5, 32'h0000_0233, 32'h0000_8005, 32'h04C1_1DB7
    };
    localparam int unsigned GEN_DEG [NUM_POLY] = '{8, 10, 16, 32};

    localparam logic [SEL_W-1:0] CRC_SELECT_RESET = 2'd3;
    localparam logic             CHECK_MODE_RESET = 1'b0;

    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic
    {
        REG_CRC_SELECT = 1'b0,
        REG_CHECK_MODE = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        KIND_DATA    = 2'd0,
        KIND_REM     = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [1:0]
    {
        CMD_ECHO     = 2'd0,
        CMD_ECHO_REM = 2'd1,
        CMD_VERDICT  = 2'd2
    } cmd_code_t;

    typedef struct packed
    {
        logic in_bit;
        logic last_in;
    } in_item_t;

    typedef struct packed
    {
        logic  out_bit;
        kind_t out_kind;
        logic  error_found;
        logic  last_out;
    } out_item_t;

    // Work handed from the front to the back
    typedef struct packed
    {
        cmd_code_t         code;
        logic              data_bit;
        logic              err;
        logic [DEG_W-1:0]  deg;
        logic [REM_W-1:0]  rem;    // remainder, left-aligned
    } cmd_t;

    // Largest polynomial not above the selection whose degree fits
    function automatic logic [SEL_W-1:0] eff_sel(input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] s;
        s = '0;
        for (int i = 0; i < NUM_POLY; i++)
        begin
            if ((SEL_W'(i) <= sel) && (GEN_DEG[i] <= MAX_DEGREE))
                s = SEL_W'(i);
        end
        return s;
    endfunction

    function automatic logic [DEG_W-1:0] sel_deg(input logic [SEL_W-1:0] s);
        return DEG_W'(GEN_DEG[s]);
    endfunction

    function automatic logic [REM_W-1:0] sel_poly(input logic [SEL_W-1:0] s);
        logic [31:0] p;
        p = GEN_POLY[s];
        return p[REM_W-1:0];
    endfunction

    function automatic logic [REM_W-1:0] sel_mask(input logic [SEL_W-1:0] s);
        logic [REM_W:0] m;
        m = (REM_W + 1)'(1) << GEN_DEG[s];
        m = m - (REM_W + 1)'(1);
        return m[REM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/cmpg_front.sv -----
// Front end: takes input bits, runs the CRC register and issues commands to the back end.
`default_nettype none

module cmpg_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire cmpg_pkg::in_item_t        in_data,
    input  wire logic [cmpg_pkg::SEL_W-1:0] crc_select,
    input  wire logic                      check_mode,
    output logic                           cmd_we,
    output cmpg_pkg::cmd_t                 cmd
);
    import cmpg_pkg::*;

    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [SEL_W-1:0]     sel;
    logic [DEG_W-1:0]     deg;
    logic [REM_W-1:0]     mask;
    logic [REM_W-1:0]     poly;
    logic [REM_W-1:0]     cur;
    logic [REM_W-1:0]     shifted;
    logic [REM_W-1:0]     upd;
    logic [BIT_IDX_W-1:0] msb_idx;
    logic                 msb;

    always_comb
    begin
        sel     = eff_sel(crc_select);
        deg     = sel_deg(sel);
        mask    = sel_mask(sel);
        poly    = sel_poly(sel);
        cur     = rem_reg & mask;
        msb_idx = BIT_IDX_W'(deg - DEG_W'(1));
        msb     = cur[msb_idx];
        shifted = {cur[REM_W-2:0], 1'b0};

        if (check_mode)
        begin
            // long division: shift the received bit in, reduce on an outgoing one
            upd = (shifted | {{(REM_W-1){1'b0}}, in_data.in_bit}) & mask;
            if (msb)
                upd = upd ^ poly;
        end
        else
        begin
            upd = shifted & mask;
            if (msb ^ in_data.in_bit)
                upd = upd ^ poly;
        end

        cmd_we = accept && (!check_mode || in_data.last_in);

        cmd.data_bit = in_data.in_bit;
        cmd.err      = |upd;
        cmd.deg      = deg;
        cmd.rem      = upd << (DEG_W'(REM_W) - deg);
        if (check_mode)
            cmd.code = CMD_VERDICT;
        else if (in_data.last_in)
            cmd.code = CMD_ECHO_REM;
        else
            cmd.code = CMD_ECHO;

        rem_next = rem_reg;
        if (accept)
            rem_next = in_data.last_in ? '0 : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

// ----- design/cmpg_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module cmpg_cmd_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire cmpg_pkg::cmd_t wr_cmd,
    input  wire logic           rd_en,
    output cmpg_pkg::cmd_t      rd_cmd,
    output logic                q_full,
    output logic                q_empty
);
    import cmpg_pkg::*;

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    always_comb
    begin
        q_full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
        q_empty = (count_reg == '0);
        do_wr   = wr_en && !q_full;
        do_rd   = rd_en && !q_empty;
        rd_cmd  = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CMD_PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CMD_PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CMD_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CMD_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cmpg_back.sv -----
// Back end: turns commands into result items and shifts out remainder bursts.
`default_nettype none

module cmpg_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire cmpg_pkg::cmd_t q_cmd,
    output logic                q_pop,
    input  wire logic           pop,
    output logic                empty,
    output cmpg_pkg::out_item_t out_data
);
    import cmpg_pkg::*;

    out_item_t        out_reg;
    out_item_t        out_next;
    logic             valid_reg;
    logic             valid_next;
    logic [REM_W-1:0] sh_reg;
    logic [REM_W-1:0] sh_next;
    logic [DEG_W-1:0] cnt_reg;
    logic [DEG_W-1:0] cnt_next;
    logic             load;

    always_comb
    begin
        out_next   = out_reg;
        valid_next = valid_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        load       = !valid_reg || pop;

        if (load)
        begin
            if (cnt_reg != '0)
            begin
                // advance the remainder burst, MSB first
                out_next = '{out_bit: sh_reg[REM_W-1], out_kind: KIND_REM,
                             error_found: 1'b0, last_out: (cnt_reg == DEG_W'(1))};
                valid_next = 1'b1;
                sh_next    = {sh_reg[REM_W-2:0], 1'b0};
                cnt_next   = cnt_reg - DEG_W'(1);
            end
            else if (!q_empty)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                unique case (q_cmd.code)
                    CMD_ECHO:
                    begin
                        out_next = '{out_bit: q_cmd.data_bit, out_kind: KIND_DATA,
                                     error_found: 1'b0, last_out: 1'b0};
                    end
                    CMD_ECHO_REM:
                    begin
                        out_next = '{out_bit: q_cmd.data_bit, out_kind: KIND_DATA,
                                     error_found: 1'b0, last_out: 1'b0};
                        sh_next  = q_cmd.rem;
                        cnt_next = q_cmd.deg;
                    end
                    CMD_VERDICT:
                    begin
                        out_next = '{out_bit: 1'b0, out_kind: KIND_VERDICT,
                                     error_found: q_cmd.err, last_out: 1'b1};
                    end
                    default:
                    begin
                        valid_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end

        empty    = !valid_reg;
        out_data = out_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sh_reg  <= sh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/crc_multi_poly_gen_check.sv -----
// Top level of the bit-serial CRC generator/checker with selectable polynomials.
//
//   Channel   Handshake             Payload
//   input     push / full           in_data  (in_bit, last_in)
//   result    empty / pop           out_data (out_bit, out_kind, error_found, last_out)
//   config    psel/penable/pwrite   paddr, pwdata, prdata, pready (always ready)
//
// One input bit can be taken every cycle while full is low; the front updates the CRC
// register in the cycle of the transfer and queues a command (four deep) for the back
// end, for each bit in generate mode and each last bit in check mode. The back end emits
// one result per cycle while pop is held; after a last bit in generate mode it shifts out
// 8, 10, 16 or 32 remainder bits, and full rises when the queue fills behind that burst.
// Reset clears the CRC register, the queue and the output stage; no clearing pass.
`default_nettype none

module crc_multi_poly_gen_check
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire cmpg_pkg::in_item_t            in_data,
    output logic                               empty,
    input  wire logic                          pop,
    output cmpg_pkg::out_item_t                out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cmpg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cmpg_pkg::PDATA_W-1:0]  pwdata,
    output logic [cmpg_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import cmpg_pkg::*;

    logic [SEL_W-1:0] crc_select_reg;
    logic [SEL_W-1:0] crc_select_next;
    logic             check_mode_reg;
    logic             check_mode_next;
    logic             cfg_we;
    reg_idx_t         reg_idx;
    logic             accept;
    logic             cmd_we;
    cmd_t             wr_cmd;
    cmd_t             rd_cmd;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    always_comb
    begin
        pready  = 1'b1;
        cfg_we  = psel && penable && pwrite && pready;
        reg_idx = reg_idx_t'(paddr[2]);

        crc_select_next = crc_select_reg;
        check_mode_next = check_mode_reg;
        unique case (reg_idx)
            REG_CRC_SELECT:
            begin
                prdata = PDATA_W'(crc_select_reg);
                if (cfg_we)
                    crc_select_next = pwdata[SEL_W-1:0];
            end
            REG_CHECK_MODE:
            begin
                prdata = PDATA_W'(check_mode_reg);
                if (cfg_we)
                    check_mode_next = pwdata[0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase

        full   = q_full;
        accept = push && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_select_reg <= CRC_SELECT_RESET;
            check_mode_reg <= CHECK_MODE_RESET;
        end
        else
        begin
            crc_select_reg <= crc_select_next;
            check_mode_reg <= check_mode_next;
        end
    end

    cmpg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_data    (in_data),
        .crc_select (crc_select_reg),
        .check_mode (check_mode_reg),
        .cmd_we     (cmd_we),
        .cmd        (wr_cmd)
    );

    cmpg_cmd_fifo u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_we),
        .wr_cmd  (wr_cmd),
        .rd_en   (q_pop),
        .rd_cmd  (rd_cmd),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    cmpg_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (rd_cmd),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ----- sim/crc_multi_poly_gen_check_tb.sv -----
// Self-checking testbench for the bit-serial multi-polynomial CRC generator and checker.
`timescale 1ns / 1ps

module crc_multi_poly_gen_check_tb;

    import cmpg_pkg::*;

    localparam logic [1:0] SEL_CRC8  = 2'd0;
    localparam logic [1:0] SEL_CRC10 = 2'd1;
    localparam logic [1:0] SEL_CRC16 = 2'd2;
    localparam logic [1:0] SEL_CRC32 = 2'd3;

    localparam logic MODE_GEN   = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam int unsigned DRAIN_CYCLES = 6;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                push    = 1'b0;
    in_item_t            in_data = '0;
    logic                pop     = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic                full;
    logic                empty;
    out_item_t           out_data;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    in_item_t    pending_bits[$];
    out_item_t   crc_results_due[$];
    out_item_t   mon_want;

    logic [31:0] crc_state  = '0;
    logic [1:0]  cfg_sel    = SEL_CRC32;
    logic        cfg_check  = MODE_GEN;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned fail_count    = 0;
    int unsigned in_count      = 0;
    int unsigned out_count     = 0;
    int unsigned verdict_count = 0;
    int unsigned setting_count = 0;

    crc_multi_poly_gen_check uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned poly_degree(input logic [1:0] s);
        case (s)
            SEL_CRC8:  return 8;
            SEL_CRC10: return 10;
            SEL_CRC16: return 16;
            default:   return 32;
        endcase
    endfunction

    function automatic logic [63:0] poly_low(input logic [1:0] s);
        case (s)
            SEL_CRC8:  return 64'h0000_00D5;
            SEL_CRC10: return 64'h0000_0233;
            SEL_CRC16: return 64'h0000_8005;
            default:   return 64'h04C1_1DB7;
        endcase
    endfunction

    // Fall back to the widest generator that the build supports
    function automatic logic [1:0] usable_sel(input logic [1:0] s);
        logic [1:0] t;
        t = s;
        while (t != SEL_CRC8 && poly_degree(t) > MAX_DEGREE)
            t = t - 2'd1;
        return t;
    endfunction

    function automatic logic [31:0] crc_of_msg(input logic [63:0] msg, input int unsigned n,
                                               input logic [1:0] s);
        logic [63:0]  r;
        logic [63:0]  mask;
        int unsigned  deg;
        logic         fb;
        deg  = poly_degree(usable_sel(s));
        mask = (64'd1 << deg) - 64'd1;
        r    = '0;
        for (int i = int'(n) - 1; i >= 0; i--)
        begin
            fb = r[deg-1] ^ msg[i];
            r  = (r << 1) & mask;
            if (fb)
                r = r ^ poly_low(usable_sel(s));
        end
        return r[31:0];
    endfunction

    // Advance the CRC register by one accepted bit and queue the results it causes
    task automatic crc_advance(input in_item_t it);
        logic [1:0]   s;
        int unsigned  deg;
        logic [63:0]  mask;
        logic [63:0]  r;
        logic         msb;
        out_item_t    o;
        s    = usable_sel(cfg_sel);
        deg  = poly_degree(s);
        mask = (64'd1 << deg) - 64'd1;
        r    = {32'd0, crc_state} & mask;
        msb  = r[deg-1];
        o    = '0;
        if (cfg_check == MODE_CHECK)
        begin
            r = ((r << 1) | {63'd0, it.in_bit}) & mask;
            if (msb)
                r = r ^ poly_low(s);
            crc_state = r[31:0];
            if (it.last_in)
            begin
                o.out_kind    = KIND_VERDICT;
                o.error_found = (r != 64'd0);
                o.last_out    = 1'b1;
                crc_results_due.insert(crc_results_due.size(), o);
                crc_state = '0;
            end
        end
        else
        begin
            r = (r << 1) & mask;
            if (msb ^ it.in_bit)
                r = r ^ poly_low(s);
            crc_state = r[31:0];
            o.out_bit  = it.in_bit;
            o.out_kind = KIND_DATA;
            crc_results_due.insert(crc_results_due.size(), o);
            if (it.last_in)
            begin
                for (int i = 0; i < int'(deg); i++)
                begin
                    o.out_bit  = r[int'(deg) - 1 - i];
                    o.out_kind = KIND_REM;
                    o.last_out = (i + 1 == int'(deg));
                    crc_results_due.insert(crc_results_due.size(), o);
                end
                crc_state = '0;
            end
        end
    endtask

    task automatic queue_bits(input logic [63:0] bits, input int unsigned n, input logic close);
        in_item_t it;
        for (int i = int'(n) - 1; i >= 0; i--)
        begin
            it.in_bit  = bits[i];
            it.last_in = close && (i == 0);
            pending_bits.insert(pending_bits.size(), it);
        end
    endtask

    function automatic logic [PADDR_W-1:0] reg_addr(input reg_idx_t r);
        return PADDR_W'(r) << 2;
    endfunction

    // Write one register, then read it back
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == REG_CRC_SELECT) ? (val & 32'h3) : (val & 32'h1);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_CRC_SELECT)
            cfg_sel = val[1:0];
        else
            cfg_check = val[0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((idx == REG_CRC_SELECT && prdata[1:0] != want[1:0]) ||
            (idx == REG_CHECK_MODE && prdata[0] != want[0]))
        begin
            $error("prdata of register %0d expected %0h got %0h", idx, want, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [1:0] sel, input logic mode);
        reg_write(REG_CRC_SELECT, {30'd0, sel});
        reg_write(REG_CHECK_MODE, {31'd0, mode});
        setting_count++;
    endtask

    // Hold until every queued bit has gone in and every due result has come out
    task automatic settle();
        while (pending_bits.size() != 0 || crc_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic build_random_phase(input int unsigned min_items, input int unsigned min_frames);
        int unsigned  frames;
        int unsigned  start;
        int unsigned  deg;
        int unsigned  mlen;
        int unsigned  pick;
        logic [63:0]  word;
        logic [63:0]  cw;
        in_item_t     it;
        frames = 0;
        start  = pending_bits.size();
        deg    = poly_degree(usable_sel(cfg_sel));
        while (pending_bits.size() - start < min_items || frames < min_frames)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
                word = {$urandom, $urandom} & ((64'd1 << mlen) - 64'd1);
                if (cfg_check == MODE_CHECK)
                begin
                    cw = (word << deg) | {32'd0, crc_of_msg(word, mlen, cfg_sel)};
                    if ($urandom_range(0, 2) == 0)
                        cw = cw ^ (64'd1 << $urandom_range(0, mlen + deg - 1));
                    queue_bits(cw, mlen + deg, 1'b1);
                end
                else
                    queue_bits(word, mlen, 1'b1);
                frames++;
            end
            else if (pick < 8)
            begin
                // frame no longer than the generator: in check mode raw bits end up as the remainder
                mlen = $urandom_range(1, deg);
                word = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
                queue_bits(word, mlen, 1'b1);
                frames++;
            end
            else
            begin
                mlen = $urandom_range(1, 12);
                for (int i = 0; i < int'(mlen); i++)
                begin
                    it.in_bit  = $urandom_range(0, 1);
                    it.last_in = (i + 1 == int'(mlen)) || ($urandom_range(0, 7) == 0);
                    if (it.last_in)
                        frames++;
                    pending_bits.insert(pending_bits.size(), it);
                end
            end
        end
    endtask

    // Drive the input and the result stall at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pop  <= 1'b0;
        end
        else
        begin
            if (pending_bits.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                push    <= 1'b1;
                in_data <= pending_bits[0];
            end
            else
                push <= 1'b0;
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            crc_advance(pending_bits.pop_front());
            in_count++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            out_count++;
            if (crc_results_due.size() == 0)
            begin
                $error("result transfer with nothing due: out_bit %0d out_kind %0d",
                       out_data.out_bit, out_data.out_kind);
                fail_count++;
            end
            else
            begin
                mon_want = crc_results_due.pop_front();
                if (mon_want.out_kind == KIND_VERDICT)
                    verdict_count++;
                if (out_data.out_bit != mon_want.out_bit)
                begin
                    $error("out_bit expected %0d got %0d", mon_want.out_bit, out_data.out_bit);
                    fail_count++;
                end
                if (out_data.out_kind != mon_want.out_kind)
                begin
                    $error("out_kind expected %0d got %0d", mon_want.out_kind, out_data.out_kind);
                    fail_count++;
                end
                if (out_data.error_found != mon_want.error_found)
                begin
                    $error("error_found expected %0d got %0d",
                           mon_want.error_found, out_data.error_found);
                    fail_count++;
                end
                if (out_data.last_out != mon_want.last_out)
                begin
                    $error("last_out expected %0d got %0d", mon_want.last_out, out_data.last_out);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("crc_multi_poly_gen_check_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 64;

        // Reset setting: single-bit frame, longest remainder burst
        queue_bits(64'h1, 1, 1'b1);
        settle();
        apply_setting(SEL_CRC8, MODE_GEN);
        queue_bits(64'hB, 4, 1'b1);
        settle();
        // Check short frames: all zero, a lone one, exactly the degree long
        apply_setting(SEL_CRC8, MODE_CHECK);
        queue_bits(64'h0, 3, 1'b1);
        queue_bits(64'h1, 1, 1'b1);
        queue_bits(64'h80, 8, 1'b1);
        settle();
        // Leave a frame open, then switch generator and mode under it
        apply_setting(SEL_CRC10, MODE_CHECK);
        queue_bits(64'h6, 3, 1'b0);
        settle();
        apply_setting(SEL_CRC32, MODE_GEN);
        queue_bits(64'h1, 1, 1'b1);
        queue_bits(64'h0, 2, 1'b1);
        settle();
        apply_setting(SEL_CRC16, MODE_GEN);
        queue_bits(64'h3, 2, 1'b1);
        settle();

        for (int p = 0; p < 12; p++)
        begin
            case (p / 4)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            apply_setting(2'(p % 4), 1'((p + p / 4) % 2));
            build_random_phase(20, 3);
            settle();
        end

        if (crc_results_due.size() != 0)
        begin
            $error("%0d results still due at the end", crc_results_due.size());
            fail_count++;
        end
        $display("Ran %0d bit transfers in, %0d result transfers out, %0d verdicts",
                 in_count, out_count, verdict_count);
        $display("Used %0d generator/mode settings under three stall patterns", setting_count);
        if (fail_count == 0)
            $display("crc_multi_poly_gen_check_tb OK");
        else
            $display("crc_multi_poly_gen_check_tb NOT OK");
        $finish;
    end

endmodule
